/* src/tcpm_pkg.sv */
// ----------------------------------------------------------------------------
// tcpm_pkg
// Shared types and constants of the timestamped capture pwm measure unit.
// ----------------------------------------------------------------------------
package tcpm_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_ONLY = 2'd2;

	// configuration reset values
	localparam logic [31:0] LEVEL_MASK_RST  = 32'h0002_0000;
	localparam logic [6:0]  CAPACITY_RST    = 7'd50;
	localparam logic        CHANGE_ONLY_RST = 1'b0;

	// item commands
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// accumulator and divider sizes
	localparam int unsigned TOTAL_W   = 40;
	localparam int unsigned NUM_W     = 47;
	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [6:0]         RISE_MAX  = 7'd127;

	// controller to datapath commands
	typedef struct packed {
		logic upd;   // item transfer, apply it to the state
		logic load;  // load both dividers
		logic step;  // one divider iteration
	} tcpm_cmd_t;

endpackage

/* src/tcpm_item_if.sv */
// ----------------------------------------------------------------------------
// tcpm_item_if
// Input item channel: command, sample and timer stamp with valid/ready.
// ----------------------------------------------------------------------------
interface tcpm_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] sample;
	logic [31:0] stamp;

	modport source (output valid, output command, output sample, output stamp, input ready);
	modport sink   (input valid, input command, input sample, input stamp, output ready);
endinterface

/* src/tcpm_result_if.sv */
// ----------------------------------------------------------------------------
// tcpm_result_if
// Result channel: status, record count, period and duty with valid/ready.
// ----------------------------------------------------------------------------
interface tcpm_result_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic        stored;
	logic [6:0]  record_count;
	logic [31:0] period;
	logic [6:0]  duty_percent;

	modport source (output valid, output ok, output stored, output record_count,
		output period, output duty_percent, input ready);
	modport sink   (input valid, input ok, input stored, input record_count,
		input period, input duty_percent, output ready);
endinterface

/* src/tcpm_ctrl.sv */
// ----------------------------------------------------------------------------
// tcpm_ctrl
// Sequencer: takes one item, loads the dividers, runs the divide iterations
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module tcpm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tcpm_pkg::tcpm_cmd_t  cmd
);
	import tcpm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// commands decoded from the state
	always_comb begin
		cmd      = '0;
		cmd.upd  = in_valid && (state_q == ST_IDLE);
		cmd.load = (state_q == ST_LOAD);
		cmd.step = (state_q == ST_DIV);
	end

	// state and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/tcpm_datapath.sv */
// ----------------------------------------------------------------------------
// tcpm_datapath
// Configuration registers, record state, period and duty accumulators and
// two bit-serial restoring dividers.
// ----------------------------------------------------------------------------
module tcpm_datapath #(
	parameter int unsigned MAX_RECORDS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tcpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	input  tcpm_pkg::tcpm_cmd_t                cmd,
	input  logic                               command,
	input  logic [31:0]                        sample,
	input  logic [31:0]                        stamp,
	output logic                               ok,
	output logic                               stored,
	output logic [6:0]                         record_count,
	output logic [31:0]                        period,
	output logic [6:0]                         duty_percent
);
	import tcpm_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

	// configuration
	logic [31:0]          level_mask_q;
	logic [6:0]           capacity_q;
	logic                 change_only_q;

	// record and accumulator state
	logic [CNT_W-1:0]     count_q;
	logic                 first_done_q;
	logic [31:0]          prev_sample_q;
	logic [31:0]          prev_stamp_q;
	logic                 rise_level_q;
	logic [6:0]           rise_count_q;
	logic [31:0]          last_rise_q;
	logic [TOTAL_W-1:0]   period_total_q;
	logic                 duty_level_q;
	logic [31:0]          last_change_q;
	logic [TOTAL_W-1:0]   high_total_q;
	logic [TOTAL_W-1:0]   low_total_q;
	logic                 ok_q;
	logic                 stored_q;

	// divider state
	logic [NUM_W-1:0]     pnum_q;
	logic [6:0]           prem_q;
	logic [6:0]           pdiv_q;
	logic                 per_en_q;
	logic [NUM_W-1:0]     dnum_q;
	logic [TOTAL_W:0]     drem_q;
	logic [TOTAL_W:0]     dsum_q;

	logic [CMP_W-1:0]     cap_lim;
	logic                 full;
	logic                 rec;
	logic                 weigh;
	logic                 lvl;
	logic [31:0]          rise_d;
	logic [31:0]          chg_d;
	logic [7:0]           prem_sh;
	logic                 pbit;
	logic [TOTAL_W+1:0]   drem_sh;
	logic                 dbit;
	logic                 per_nz;

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
		input logic [31:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + (TOTAL_W+1)'(b);
		return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_mask_q  <= LEVEL_MASK_RST;
			capacity_q    <= CAPACITY_RST;
			change_only_q <= CHANGE_ONLY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_MASK:  level_mask_q  <= cfg_data;
				CFG_CAPACITY:    capacity_q    <= cfg_data[6:0];
				CFG_CHANGE_ONLY: change_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// record decision
	always_comb begin
		cap_lim = (CMP_W'(capacity_q) > CMP_W'(MAX_RECORDS)) ? CMP_W'(MAX_RECORDS)
			: CMP_W'(capacity_q);
		full    = CMP_W'(count_q) >= cap_lim;
		rec     = (command == CMD_RECORD) && !full && (!change_only_q || !first_done_q
			|| ((count_q != '0) && (prev_sample_q != sample)));
		weigh   = rec && (count_q != '0);
		lvl     = |(prev_sample_q & level_mask_q);
		rise_d  = last_rise_q - prev_stamp_q;
		chg_d   = last_change_q - prev_stamp_q;
	end

	// item update: clear, or record and weigh the previous record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			first_done_q   <= 1'b0;
			prev_sample_q  <= '0;
			prev_stamp_q   <= '0;
			rise_level_q   <= 1'b0;
			rise_count_q   <= '0;
			last_rise_q    <= '0;
			period_total_q <= '0;
			duty_level_q   <= 1'b0;
			last_change_q  <= '0;
			high_total_q   <= '0;
			low_total_q    <= '0;
			ok_q           <= 1'b0;
			stored_q       <= 1'b0;
		end else if (cmd.upd) begin
			if (command == CMD_CLEAR) begin
				count_q        <= '0;
				first_done_q   <= 1'b0;
				prev_sample_q  <= '0;
				prev_stamp_q   <= '0;
				rise_level_q   <= 1'b0;
				rise_count_q   <= '0;
				last_rise_q    <= '0;
				period_total_q <= '0;
				duty_level_q   <= 1'b0;
				last_change_q  <= '0;
				high_total_q   <= '0;
				low_total_q    <= '0;
				ok_q           <= 1'b1;
				stored_q       <= 1'b0;
			end else begin
				ok_q     <= !full;
				stored_q <= rec;
				if (!full && change_only_q) begin
					first_done_q <= 1'b1;
				end
				if (rec) begin
					prev_sample_q <= sample;
					prev_stamp_q  <= stamp;
					count_q       <= count_q + CNT_W'(1);
				end
				// rise tracking
				if (weigh) begin
					if (lvl) begin
						if (!rise_level_q) begin
							if (rise_count_q != '0) begin
								period_total_q <= sat_add(period_total_q, rise_d);
							end
							if (rise_count_q < RISE_MAX) begin
								rise_count_q <= rise_count_q + 7'd1;
							end
							last_rise_q <= prev_stamp_q;
						end
						rise_level_q <= 1'b1;
					end else begin
						rise_level_q <= 1'b0;
					end
					// level change tracking, the oldest record only sets the start
					if (count_q == CNT_W'(1)) begin
						last_change_q <= prev_stamp_q;
						duty_level_q  <= lvl;
					end else if (lvl != duty_level_q) begin
						if (lvl) begin
							low_total_q <= sat_add(low_total_q, chg_d);
						end else begin
							high_total_q <= sat_add(high_total_q, chg_d);
						end
						last_change_q <= prev_stamp_q;
						duty_level_q  <= lvl;
					end
				end
			end
		end
	end

	// divider iteration
	always_comb begin
		prem_sh = {prem_q, pnum_q[NUM_W-1]};
		pbit    = prem_sh >= {1'b0, pdiv_q};
		drem_sh = {drem_q, dnum_q[NUM_W-1]};
		dbit    = drem_sh >= {1'b0, dsum_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnum_q   <= '0;
			prem_q   <= '0;
			pdiv_q   <= '0;
			per_en_q <= 1'b0;
			dnum_q   <= '0;
			drem_q   <= '0;
			dsum_q   <= '0;
		end else if (cmd.load) begin
			pnum_q   <= NUM_W'(period_total_q);
			prem_q   <= '0;
			pdiv_q   <= rise_count_q - 7'd1;
			per_en_q <= (count_q >= CNT_W'(3)) && (rise_count_q >= 7'd2);
			// 100 * high as 64 + 32 + 4
			dnum_q   <= NUM_W'({high_total_q, 6'b0}) + NUM_W'({high_total_q, 5'b0})
				+ NUM_W'({high_total_q, 2'b0});
			drem_q   <= '0;
			dsum_q   <= {1'b0, high_total_q} + {1'b0, low_total_q};
		end else if (cmd.step) begin
			if (pbit) begin
				prem_q <= 7'(prem_sh - {1'b0, pdiv_q});
			end else begin
				prem_q <= prem_sh[6:0];
			end
			pnum_q <= {pnum_q[NUM_W-2:0], pbit};
			if (dbit) begin
				drem_q <= (TOTAL_W+1)'(drem_sh - {1'b0, dsum_q});
			end else begin
				drem_q <= drem_sh[TOTAL_W:0];
			end
			dnum_q <= {dnum_q[NUM_W-2:0], dbit};
		end
	end

	// result fields
	always_comb begin
		per_nz       = per_en_q && (pnum_q[TOTAL_W-1:0] != '0);
		ok           = ok_q;
		stored       = stored_q;
		record_count = 7'(count_q);
		period       = per_en_q ? pnum_q[31:0] : 32'd0;
		duty_percent = (per_nz && (dsum_q != '0)) ? dnum_q[6:0] : 7'd0;
	end

endmodule

/* src/timestamped_capture_pwm_measure_unit.sv */
// ----------------------------------------------------------------------------
// timestamped_capture_pwm_measure_unit
// PWM period and duty measurement over timestamped sample captures.
// ----------------------------------------------------------------------------
// After an input transfer the unit runs a load step and then the iterations
// of the two bit-serial dividers; the result is held until it is taken.
// Only one item is in flight at a time.
// Reset: asynchronous, clears all records and accumulators, level_mask to
// 0x20000, capacity to 50, change_only to 0.
module timestamped_capture_pwm_measure_unit #(
	parameter int unsigned MAX_RECORDS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	tcpm_item_if.sink                       item_in,
	tcpm_result_if.source                   result_out
);
	import tcpm_pkg::*;

	tcpm_cmd_t cmd;

	// sequencer
	tcpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd)
	);

	// state, accumulators and dividers
	tcpm_datapath #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.command      (item_in.command),
		.sample       (item_in.sample),
		.stamp        (item_in.stamp),
		.ok           (result_out.ok),
		.stored       (result_out.stored),
		.record_count (result_out.record_count),
		.period       (result_out.period),
		.duty_percent (result_out.duty_percent)
	);

endmodule

/* sim/tb_timestamped_capture_pwm_measure_unit.sv */
// ----------------------------------------------------------------------------
// tb_timestamped_capture_pwm_measure_unit
// Self-checking bench for the pwm period and duty measurement unit. A short
// directed run covers timer wrap, change-only skips, a full buffer and a
// capacity of zero. It is followed by random phases of pwm-shaped capture
// runs under varying register settings. Both channels stall at random. A
// measurement predictor inside the scoreboard checks every result transfer.
// ----------------------------------------------------------------------------
module tb_timestamped_capture_pwm_measure_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpm_pkg::*;

	localparam int unsigned MAX_REC     = 64;
	localparam int unsigned ITEM_GOAL   = 1950;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        ok;
		logic        stored;
		logic [6:0]  record_count;
		logic [31:0] period;
		logic [6:0]  duty_percent;
	} meas_t;

	// measurement predictor and expected result store
	class pwm_meas_scoreboard;
		meas_t       meas_expected[$];
		int unsigned errors;

		logic [31:0] level_mask;
		logic [6:0]  capacity;
		logic        change_only;

		logic [6:0]  count;
		logic        first_done;
		logic [31:0] prev_sample;
		logic [31:0] prev_stamp;
		logic        rise_level;
		logic [6:0]  rise_count;
		logic [31:0] last_rise;
		logic [39:0] period_total;
		logic        duty_level;
		logic [31:0] last_change;
		logic [39:0] high_total;
		logic [39:0] low_total;

		function new();
			errors      = 0;
			level_mask  = LEVEL_MASK_RST;
			capacity    = CAPACITY_RST;
			change_only = CHANGE_ONLY_RST;
			clear_meas();
		endfunction

		function void clear_meas();
			count        = '0;
			first_done   = 1'b0;
			prev_sample  = '0;
			prev_stamp   = '0;
			rise_level   = 1'b0;
			rise_count   = '0;
			last_rise    = '0;
			period_total = '0;
			duty_level   = 1'b0;
			last_change  = '0;
			high_total   = '0;
			low_total    = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				CFG_LEVEL_MASK:  level_mask  = val;
				CFG_CAPACITY:    capacity    = val[6:0];
				CFG_CHANGE_ONLY: change_only = val[0];
				default: ;
			endcase
		endfunction

		function logic [39:0] sat_total(logic [39:0] acc, logic [31:0] d);
			logic [40:0] s;
			s = {1'b0, acc} + {9'b0, d};
			return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[39:0];
		endfunction

		// the previous record becomes weighable once a new one arrives
		function void add_record(logic [31:0] smp, logic [31:0] stp);
			logic lvl;
			if (count >= 7'd1) begin
				lvl = (prev_sample & level_mask) != 32'd0;
				if (lvl) begin
					if (!rise_level) begin
						if (rise_count != 7'd0)
							period_total = sat_total(period_total, last_rise - prev_stamp);
						if (rise_count < RISE_MAX)
							rise_count++;
						last_rise = prev_stamp;
					end
					rise_level = 1'b1;
				end else begin
					rise_level = 1'b0;
				end
				if (count == 7'd1) begin
					last_change = prev_stamp;
					duty_level  = lvl;
				end else if (lvl != duty_level) begin
					if (lvl)
						low_total = sat_total(low_total, last_change - prev_stamp);
					else
						high_total = sat_total(high_total, last_change - prev_stamp);
					last_change = prev_stamp;
					duty_level  = lvl;
				end
			end
			prev_sample = smp;
			prev_stamp  = stp;
			count++;
		endfunction

		// apply one accepted item and queue the result it must produce
		function void note_capture(logic cmd, logic [31:0] smp, logic [31:0] stp);
			logic [6:0]  cap_eff;
			logic [63:0] period_full;
			logic [63:0] sum;
			logic [63:0] duty_full;
			meas_t       want;
			cap_eff     = (capacity > 7'(MAX_REC)) ? 7'(MAX_REC) : capacity;
			want.ok     = 1'b1;
			want.stored = 1'b0;
			if (cmd == CMD_CLEAR) begin
				clear_meas();
			end else if (count >= cap_eff) begin
				want.ok = 1'b0;
			end else if (!change_only) begin
				add_record(smp, stp);
				want.stored = 1'b1;
			end else begin
				if (!first_done || (count > 7'd0 && prev_sample != smp)) begin
					add_record(smp, stp);
					want.stored = 1'b1;
				end
				first_done = 1'b1;
			end
			period_full = '0;
			duty_full   = '0;
			if (count >= 7'd3 && rise_count >= 7'd2)
				period_full = 64'(period_total) / (64'(rise_count) - 64'd1);
			if (period_full != 64'd0) begin
				sum = 64'(high_total) + 64'(low_total);
				if (sum != 64'd0)
					duty_full = (64'd100 * 64'(high_total)) / sum;
			end
			want.record_count = count;
			want.period       = period_full[31:0];
			want.duty_percent = duty_full[6:0];
			meas_expected.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_meas(meas_t got);
			meas_t want;
			if (meas_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				return;
			end
			want = meas_expected.pop_front();
			compare_field("ok", 32'(want.ok), 32'(got.ok));
			compare_field("stored", 32'(want.stored), 32'(got.stored));
			compare_field("record_count", 32'(want.record_count), 32'(got.record_count));
			compare_field("period", want.period, got.period);
			compare_field("duty_percent", 32'(want.duty_percent), 32'(got.duty_percent));
		endfunction

		function int unsigned pending();
			return meas_expected.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	tcpm_item_if   item_ch();
	tcpm_result_if result_ch();

	pwm_meas_scoreboard meas_sb;
	logic               steady;
	int unsigned        items_sent;

	timestamped_capture_pwm_measure_unit #(
		.MAX_RECORDS(MAX_REC)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_in    (item_ch),
		.result_out (result_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one item transfer, with random idle cycles ahead of it
	task automatic send_item(input logic cmd, input logic [31:0] smp, input logic [31:0] stp);
		while (!steady && $urandom_range(99) < 15) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.command <= cmd;
		item_ch.sample  <= smp;
		item_ch.stamp   <= stp;
		do @(posedge clk); while (!item_ch.ready);
		meas_sb.note_capture(cmd, smp, stp);
		items_sent++;
	endtask

	// stop offering items and wait for every outstanding result
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (meas_sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		meas_sb.set_reg(idx, val);
	endtask

	// full register set, junk in the unused upper bits
	task automatic configure(input logic [31:0] mask, input logic [6:0] cap, input logic co);
		cfg_write(CFG_UNUSED, $urandom());
		cfg_write(CFG_LEVEL_MASK, mask);
		cfg_write(CFG_CAPACITY, {25'($urandom()), cap});
		cfg_write(CFG_CHANGE_ONLY, {31'($urandom()), co});
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, check every transfer
	initial begin
		meas_t got;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.ok, result_ch.stored, result_ch.record_count,
					result_ch.period, result_ch.duty_percent};
				meas_sb.check_meas(got);
			end
			result_ch.ready <= steady || ($urandom_range(99) >= 15);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL timestamped_capture_pwm_measure_unit");
		$finish;
	end

	// stimulus
	initial begin
		logic [31:0] pm;
		logic [6:0]  pc;
		logic        pco;
		logic [6:0]  cap_eff;
		logic [31:0] data;
		logic [31:0] stp;
		logic        lvl;
		int unsigned run;
		int unsigned phase_start;
		int unsigned roll;

		meas_sb         = new();
		steady          = 1'b0;
		items_sent      = 0;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_LEVEL_MASK;
		cfg_data        <= '0;
		item_ch.valid   <= 1'b0;
		item_ch.command <= CMD_RECORD;
		item_ch.sample  <= '0;
		item_ch.stamp   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: timer wraps between the first two records
		send_item(CMD_RECORD, 32'h0000_0000, 32'h0000_0000);
		send_item(CMD_RECORD, 32'h0002_0000, 32'hFFFF_FF00);
		send_item(CMD_RECORD, 32'hFFFD_FFFF, 32'hFFFF_FE80);
		send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FE00);
		send_item(CMD_RECORD, 32'h0000_0001, 32'hFFFF_FDA0);
		send_item(CMD_RECORD, 32'h0002_0000, 32'hFFFF_FD00);
		send_item(CMD_RECORD, 32'h0000_0000, 32'hFFFF_FC00);
		send_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// change-only: first offer after clear kept, repeats skipped, then full
		settle();
		configure(32'h0000_0001, 7'd3, 1'b1);
		send_item(CMD_RECORD, 32'h0000_0001, 32'd1000);
		send_item(CMD_RECORD, 32'h0000_0001, 32'd900);
		send_item(CMD_RECORD, 32'h0000_0000, 32'd800);
		send_item(CMD_RECORD, 32'h0000_0001, 32'd700);
		send_item(CMD_RECORD, 32'h0000_0000, 32'd600);
		send_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
		send_item(CMD_RECORD, 32'h0000_0000, 32'd500);

		// capacity of zero is always full
		settle();
		configure(32'hFFFF_FFFF, 7'd0, 1'b0);
		send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'd0);
		send_item(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);

		// random phases of pwm-shaped capture runs
		for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
			case (phase)
				0: begin pm = 32'hFFFF_FFFF; pc = 7'd64;  pco = 1'b0; end
				1: begin pm = 32'h0000_0000; pc = 7'd1;   pco = 1'b1; end
				2: begin pm = 32'h0000_0001; pc = 7'd127; pco = 1'b1; end
				3: begin pm = 32'h8000_0000; pc = 7'd0;   pco = 1'b0; end
				default: begin
					pm  = ($urandom_range(1) == 0) ? (32'd1 << $urandom_range(31)) : $urandom();
					pc  = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 65))
						: 7'($urandom_range(64, 2));
					pco = 1'($urandom_range(1));
				end
			endcase
			settle();
			configure(pm, pc, pco);
			steady      = (phase == 6 || phase == 7);
			phase_start = items_sent;
			cap_eff     = (pc > 7'(MAX_REC)) ? 7'(MAX_REC) : pc;
			while (items_sent - phase_start < 150 && items_sent < ITEM_GOAL) begin
				send_item(CMD_CLEAR, $urandom(), $urandom());
				run  = (cap_eff == 7'd0) ? $urandom_range(4, 1) : $urandom_range(cap_eff + 3, 1);
				stp  = $urandom();
				lvl  = 1'($urandom_range(1));
				data = $urandom();
				for (int k = 0; k < run; k++) begin
					roll = $urandom_range(99);
					if (roll < 4) begin
						send_item(CMD_CLEAR, $urandom(), $urandom());
					end else if (roll < 12) begin
						send_item(CMD_RECORD, $urandom(), $urandom());
					end else begin
						// repeat the last sample now and then so change-only skips
						if (!(pco && $urandom_range(3) == 0)) begin
							if ($urandom_range(99) < 35)
								lvl = !lvl;
							data = $urandom();
							if (lvl) begin
								data = data | (pm & $urandom());
								if ((data & pm) == 32'd0)
									data = data | (pm & (~pm + 32'd1));
							end else begin
								data = data & ~pm;
							end
						end
						stp = stp - (($urandom_range(19) == 0) ? $urandom()
							: $urandom_range(4000, 1));
						send_item(CMD_RECORD, data, stp);
					end
				end
			end
		end

		steady = 1'b0;
		settle();
		repeat (60) @(posedge clk);
		if (meas_sb.errors == 0 && meas_sb.pending() == 0)
			$display("PASS timestamped_capture_pwm_measure_unit");
		else
			$display("FAIL timestamped_capture_pwm_measure_unit");
		$finish;
	end

endmodule

/* files.f */
src/tcpm_pkg.sv
src/tcpm_item_if.sv
src/tcpm_result_if.sv
src/tcpm_ctrl.sv
src/tcpm_datapath.sv
src/timestamped_capture_pwm_measure_unit.sv
sim/tb_timestamped_capture_pwm_measure_unit.sv
